// ===== sv/buddy_block_allocator_macros.svh =====
// assertion macros for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BBA_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define BBA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_MEMORY = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_STACK_FULL = 3'd4
  } status_e;

  localparam int unsigned GrowMinOrder  = 6;
  localparam int unsigned GrowBumpBelow = 16;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ORDER  = 9'b000000010,
    S_SEARCH = 9'b000000100,
    S_GROW   = 9'b000001000,
    S_CHECK  = 9'b000010000,
    S_POP    = 9'b000100000,
    S_POPW   = 9'b001000000,
    S_SPLIT  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;
endpackage
`default_nettype wire

// ===== sv/bba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1280
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/buddy_block_allocator.sv =====
// buddy block allocator, allocation side
// s_axis carries one request (byte count); m_axis returns one result per
// request: payload offset, status and block order. cfg_* writes the heap
// limit, only while the block is idle.
// one request at a time: s_axis_tready is high only in idle. an item passes
// through idle, one order step per size doubling up to the requested order,
// an upward scan over the orders, a growth check when every stack from the
// requested order up is empty, a check pass over the split orders, a stack
// pop from the block store (pop and pop-wait states), the split write-backs
// and the output state; a zero size request goes straight from idle to
// output. the single-port write of the free stack store sets the split rate.
// stack counts live in flip-flops and clear at reset, as do the heap top and
// the limit (reset 16777216); the store needs no clearing.
// the result sits in an output register until m_axis_tready; a stalled
// receiver holds the block in its output state and no new request is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_block_allocator_macros.svh"
module buddy_block_allocator #(
  parameter int unsigned MIN_BLOCK_BYTES = 32,
  parameter int unsigned HEADER_BYTES    = 32,
  parameter int unsigned ORDER_COUNT     = 20,
  parameter int unsigned STACK_DEPTH     = 64,
  parameter int unsigned ADDR_BITS       = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // request_bytes
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // payload_offset, status_code, block_order
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [24:0] cfg_data_i      // heap_limit_bytes
);
  localparam int unsigned OrdW   = $clog2(ORDER_COUNT + 1);
  localparam int unsigned CntW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SlotW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned Depth  = ORDER_COUNT * STACK_DEPTH;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned TopW   = ADDR_BITS + 2;
  localparam int unsigned OrdIdxW = $clog2(ORDER_COUNT);

  bba_pkg::state_e state_q, state_d;
  logic [CntW-1:0]   cnt_q [ORDER_COUNT];
  logic [TopW-1:0]   top_q;
  logic [24:0]       limit_q;
  logic [25:0]       total_q;
  logic [OrdW-1:0]   order_q, src_q, k_q;
  logic [TopW-1:0]   blk_q;
  logic [TopW-1:0]   bsize_q;
  logic              grow_q;
  logic [23:0]       off_q;
  logic [2:0]        st_q;
  logic [4:0]        ord_out_q;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [ADDR_BITS-1:0] wdata, rdata;

  bba_ram #(.Width(ADDR_BITS), .Depth(Depth)) u_store (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [AddrW-1:0] slot(input logic [OrdW-1:0] o,
                                            input logic [CntW-1:0] c);
    logic [AddrW+CntW:0] a;
    a = (AddrW+CntW+1)'(o) * (AddrW+CntW+1)'(STACK_DEPTH)
        + (AddrW+CntW+1)'(c[SlotW-1:0]);
    return a[AddrW-1:0];
  endfunction

  logic [TopW:0] lim_eff;
  assign lim_eff = ({1'b0, limit_q} > (TopW+1)'(1) << ADDR_BITS) ?
                   ((TopW+1)'(1) << ADDR_BITS) : (TopW+1)'(limit_q);

  logic [CntW-1:0] cnt_k, cnt_src;
  assign cnt_k   = cnt_q[k_q[OrdIdxW-1:0]];
  assign cnt_src = cnt_q[src_q[OrdIdxW-1:0]];
  logic [OrdW-1:0] lo;
  assign lo = k_q - OrdW'(1);

  assign s_axis_tready = (state_q == bba_pkg::S_IDLE);
  assign cfg_ready_o   = (state_q == bba_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == bba_pkg::S_OUT);
  assign m_axis_tdata  = {ord_out_q, st_q, off_q};

  always_comb begin
    we = 1'b0;
    waddr = slot(lo, cnt_q[lo[OrdIdxW-1:0]]);
    wdata = ADDR_BITS'(blk_q + (bsize_q >> 1));
    // in the pop state the count is already decremented and names the top entry
    raddr = slot(src_q, cnt_src);
    if (state_q == bba_pkg::S_SPLIT && k_q > order_q) we = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_IDLE;
      for (int i = 0; i < ORDER_COUNT; i++) cnt_q[i] <= '0;
      top_q <= '0;
      limit_q <= 25'd16777216;
    end else begin
      unique case (state_q)
        bba_pkg::S_IDLE: begin
          if (cfg_valid_i) limit_q <= cfg_data_i;
          if (s_axis_tvalid) begin
            if (s_axis_tdata == '0) begin
              off_q <= '0; st_q <= bba_pkg::ST_ZERO_SIZE; ord_out_q <= '0;
              state_q <= bba_pkg::S_OUT;
            end else begin
              total_q <= (26'(s_axis_tdata) + 26'(HEADER_BYTES) < 26'(MIN_BLOCK_BYTES)) ?
                         26'(MIN_BLOCK_BYTES) : 26'(s_axis_tdata) + 26'(HEADER_BYTES);
              order_q <= '0;
              bsize_q <= TopW'(MIN_BLOCK_BYTES);
              state_q <= bba_pkg::S_ORDER;
            end
          end
        end
        bba_pkg::S_ORDER: begin
          if (order_q >= OrdW'(ORDER_COUNT)) begin
            off_q <= '0; st_q <= bba_pkg::ST_TOO_LARGE; ord_out_q <= '0;
            state_q <= bba_pkg::S_OUT;
          end else if ((TopW+1)'(bsize_q) < (TopW+1)'(total_q)) begin
            order_q <= order_q + OrdW'(1);
            bsize_q <= bsize_q << 1;
          end else begin
            src_q <= order_q;
            state_q <= bba_pkg::S_SEARCH;
          end
        end
        bba_pkg::S_SEARCH: begin
          if (src_q >= OrdW'(ORDER_COUNT)) begin
            grow_q <= 1'b1;
            if (order_q < OrdW'(bba_pkg::GrowMinOrder)) src_q <= OrdW'(bba_pkg::GrowMinOrder);
            else if (order_q < OrdW'(bba_pkg::GrowBumpBelow)) src_q <= order_q + OrdW'(1);
            else src_q <= order_q;
            state_q <= bba_pkg::S_GROW;
          end else if (cnt_src != '0) begin
            grow_q <= 1'b0;
            k_q <= order_q;
            state_q <= bba_pkg::S_CHECK;
          end else begin
            src_q <= src_q + OrdW'(1);
          end
        end
        bba_pkg::S_GROW: begin
          if (src_q >= OrdW'(ORDER_COUNT) ||
              (TopW+1)'(top_q) > lim_eff ||
              ((TopW+1)'(MIN_BLOCK_BYTES) << src_q) > lim_eff - (TopW+1)'(top_q)) begin
            off_q <= '0; st_q <= bba_pkg::ST_NO_MEMORY; ord_out_q <= 5'(order_q);
            state_q <= bba_pkg::S_OUT;
          end else begin
            k_q <= order_q;
            state_q <= bba_pkg::S_CHECK;
          end
        end
        bba_pkg::S_CHECK: begin
          if (k_q >= src_q) begin
            k_q <= src_q;
            bsize_q <= TopW'(MIN_BLOCK_BYTES) << src_q;
            if (grow_q) begin
              blk_q <= top_q;
              top_q <= top_q + (TopW'(MIN_BLOCK_BYTES) << src_q);
              state_q <= bba_pkg::S_SPLIT;
            end else begin
              cnt_q[src_q[OrdIdxW-1:0]] <= cnt_src - CntW'(1);
              state_q <= bba_pkg::S_POP;
            end
          end else if (cnt_k >= CntW'(STACK_DEPTH)) begin
            off_q <= '0; st_q <= bba_pkg::ST_STACK_FULL; ord_out_q <= 5'(order_q);
            state_q <= bba_pkg::S_OUT;
          end else begin
            k_q <= k_q + OrdW'(1);
          end
        end
        bba_pkg::S_POP: state_q <= bba_pkg::S_POPW;
        bba_pkg::S_POPW: begin
          blk_q <= TopW'(rdata);
          state_q <= bba_pkg::S_SPLIT;
        end
        bba_pkg::S_SPLIT: begin
          if (k_q > order_q) begin
            cnt_q[lo[OrdIdxW-1:0]] <= cnt_q[lo[OrdIdxW-1:0]] + CntW'(1);
            k_q <= lo;
            bsize_q <= bsize_q >> 1;
          end else begin
            off_q <= 24'(blk_q + TopW'(HEADER_BYTES));
            st_q <= bba_pkg::ST_OK; ord_out_q <= 5'(order_q);
            state_q <= bba_pkg::S_OUT;
          end
        end
        bba_pkg::S_OUT: if (m_axis_tready) state_q <= bba_pkg::S_IDLE;
        default: state_q <= bba_pkg::S_IDLE;
      endcase
    end
  end

  `BBA_ASSERT_IMPL(a_one_hot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `BBA_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, m_axis_tvalid && st_q != bba_pkg::ST_OK,
                   off_q == '0)
  `BBA_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire

// ===== test/tb_buddy_block_allocator.sv =====
`timescale 1ns / 1ps
module tb_buddy_block_allocator;

  localparam int unsigned MinBlock   = 32;
  localparam int unsigned HdrBytes   = 32;
  localparam int unsigned NumOrders  = 20;
  localparam int unsigned Depth      = 64;
  localparam int unsigned AddrBits   = 24;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct packed {
    logic [4:0]       order;
    bba_pkg::status_e status;
    logic [23:0]      offset;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;     // request_bytes
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // payload_offset, status_code, block_order
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [24:0] cfg_data_i = '0;

  buddy_block_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // allocator mirror
  logic [23:0] free_offsets [NumOrders][Depth];
  int unsigned free_counts [NumOrders];
  longint unsigned heap_top_m;
  longint unsigned heap_limit_m;

  alloc_result_t expected_results[$];
  int unsigned   errors;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   hold_left;
  bit            hold_req;
  longint unsigned cycles;

  function automatic longint unsigned blk_bytes(int unsigned k);
    return longint'(MinBlock) << k;
  endfunction

  function automatic alloc_result_t allocate(logic [23:0] req);
    alloc_result_t   r;
    longint unsigned total, lim, blk;
    int unsigned     ord, src, k;
    bit              grow;
    r = '{order: '0, status: bba_pkg::ST_OK, offset: '0};
    if (req == 0) begin
      r.status = bba_pkg::ST_ZERO_SIZE;
      return r;
    end
    total = longint'(req) + HdrBytes;
    if (total < MinBlock) total = MinBlock;
    ord = 0;
    while (ord < NumOrders && blk_bytes(ord) < total) ord++;
    if (ord >= NumOrders) begin
      r.status = bba_pkg::ST_TOO_LARGE;
      return r;
    end
    r.order = ord[4:0];
    src = ord;
    while (src < NumOrders && free_counts[src] == 0) src++;
    grow = (src >= NumOrders);
    if (grow) begin
      if (ord < bba_pkg::GrowMinOrder) src = bba_pkg::GrowMinOrder;
      else if (ord < bba_pkg::GrowBumpBelow) src = ord + 1;
      else src = ord;
      lim = heap_limit_m;
      if (lim > (64'd1 << AddrBits)) lim = 64'd1 << AddrBits;
      if (src >= NumOrders || heap_top_m > lim || blk_bytes(src) > lim - heap_top_m) begin
        r.status = bba_pkg::ST_NO_MEMORY;
        return r;
      end
    end
    for (k = ord; k < src; k++) begin
      if (free_counts[k] >= Depth) begin
        r.status = bba_pkg::ST_STACK_FULL;
        return r;
      end
    end
    if (grow) begin
      blk = heap_top_m;
      heap_top_m = heap_top_m + blk_bytes(src);
    end else begin
      free_counts[src]--;
      blk = free_offsets[src][free_counts[src]];
    end
    for (k = src; k > ord; k--) begin
      free_offsets[k-1][free_counts[k-1]] = 24'(blk + blk_bytes(k-1));
      free_counts[k-1]++;
    end
    r.offset = 24'(blk + HdrBytes);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    alloc_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = alloc_result_t'(m_axis_tdata);
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.offset !== want.offset) begin
          $display("%0t offset exp %h got %h", $time, want.offset, got.offset);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.order !== want.order) begin
          $display("%0t order exp %0d got %0d", $time, want.order, got.order);
          errors++;
        end
      end
    end
  end

  // receiver readiness
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(logic [23:0] req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(allocate(req));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [24:0] lim);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    heap_limit_m = lim;
  endtask

  function automatic logic [23:0] random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) return 24'd0;
    if (pick < 65) return 24'($urandom_range(2000, 1));
    if (pick < 88) return 24'($urandom_range(70000, 1));
    if (pick < 96) return 24'($urandom_range(16777184, 70000));
    return 24'($urandom);
  endfunction

  task automatic test_directed();
    logic [23:0] reqs[$];
    write_limit(25'd0);
    send_request(24'd1);
    send_request(24'd100);
    write_limit(25'h1000000);
    reqs = '{24'd0, 24'hFFFFFF, 24'd16777185, 24'd1, 24'd2, 24'd32, 24'd33, 24'd100,
             24'd480, 24'd2016, 24'd2017, 24'd65504, 24'h555555, 24'hAAAAAA,
             24'd16777184, 24'd1000, 24'd5};
    foreach (reqs[i]) send_request(reqs[i]);
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) send_request(random_request());
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) send_request(24'($urandom_range(3000, 1)));
    drain();
    repeat (10) send_request(24'($urandom_range(3000, 1)));
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_left = 0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    heap_top_m = 0;
    heap_limit_m = 64'd16777216;
    foreach (free_counts[i]) free_counts[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 17;
    recv_idle_pct = 64;
    test_directed();
    write_limit(25'd4096);
    test_random(140);
    write_limit(25'h0100000);
    send_idle_pct = 64;
    recv_idle_pct = 17;
    test_random(140);
    test_backpressure();
    write_limit(25'h1FFFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);

    drain();
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/bba_pkg.sv
sv/bba_ram.sv
sv/buddy_block_allocator.sv
test/tb_buddy_block_allocator.sv
